// File: hdl/whole_word_replacer_assert.svh
// Assertion macros shared by the whole_word_replacer RTL.
// Each expects clk and rst_n in scope at the point of use.
`ifndef WHOLE_WORD_REPLACER_ASSERT_SVH
`define WHOLE_WORD_REPLACER_ASSERT_SVH

// Same-cycle implication.
`define WWR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("whole_word_replacer: same-cycle check failed");

// Next-cycle implication.
`define WWR_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("whole_word_replacer: next-cycle check failed");

`endif

// File: hdl/wwr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wwr_pkg;

    localparam int BYTE_W             = 8;
    localparam int CNT_W              = 4;
    localparam int MAX_WORD_BYTES_DEF = 8;
    // longest burst of data bytes in one job: a full word plus the byte that overflows it
    localparam int JOB_BYTES          = 9;
    localparam int Q_DEPTH            = 4;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 64;

    localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WORD        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LENGTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_WORD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CASE         = 3'd4;

    typedef struct packed {
        logic [63:0]      target_word;
        logic [CNT_W-1:0] target_length;
        logic [63:0]      replacement_word;
        logic [CNT_W-1:0] replacement_length;
        logic             match_case;
    } cfg_t;

    typedef struct packed {
        logic                       last;
        logic                       sep;
        logic [CNT_W-1:0]           n;
        logic [JOB_BYTES*BYTE_W-1:0] data;
    } job_t;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic mc);
        logic [BYTE_W-1:0] r;
        r = b;
        if (!mc && b >= 8'd65 && b <= 8'd90)
            r = b + 8'd32;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/wwr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wwr_front import wwr_pkg::*; #(
    parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              in_last,
    input  wire logic              in_empty,
    output logic                   push,
    output job_t                   job
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WORD_BYTES);

    logic [BYTE_W-1:0] word_mem [MAX_WORD_BYTES];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pass_reg, pass_next;
    logic              emitted_reg, emitted_next;

    logic is_sp, store, flush, passb, emit_word, match;
    logic [CNT_W-1:0] eff_cnt, rep_len;
    logic [JOB_BYTES-1:0][BYTE_W-1:0] eff;

    always_comb
    begin
        is_sp     = !in_empty && (in_byte == SPACE_BYTE);
        store     = !in_empty && !is_sp && !pass_reg && (count_reg < MAX_CNT);
        flush     = !in_empty && !is_sp && !pass_reg && (count_reg >= MAX_CNT);
        passb     = !in_empty && !is_sp && pass_reg;
        eff_cnt   = count_reg + CNT_W'(store || flush);
        emit_word = (is_sp || in_last) && !pass_reg && !flush && (eff_cnt != '0);
    end

    // current word with the incoming byte dropped into its slot
    always_comb
    begin
        eff = '0;
        for (int i = 0; i < MAX_WORD_BYTES; i++)
            eff[i] = word_mem[i];
        for (int i = 0; i < JOB_BYTES; i++)
            if ((store || flush) && count_reg == CNT_W'(i))
                eff[i] = in_byte;
    end

    always_comb
    begin
        match = (eff_cnt == cfg.target_length);
        for (int i = 0; i < 8; i++)
            if (CNT_W'(i) < eff_cnt &&
                fold_byte(eff[i], cfg.match_case) !=
                fold_byte(cfg.target_word[i*BYTE_W +: BYTE_W], cfg.match_case))
                match = 1'b0;
        rep_len = (cfg.replacement_length > 4'd8) ? 4'd8 : cfg.replacement_length;
    end

    always_comb
    begin
        job.last = in_last;
        job.sep  = (emit_word || flush) && emitted_reg;
        job.n    = '0;
        job.data = eff;
        priority if (passb)
        begin
            job.n    = 4'd1;
            job.data = {{(JOB_BYTES-1)*BYTE_W{1'b0}}, in_byte};
        end
        else if (flush)
        begin
            job.n = eff_cnt;
        end
        else if (emit_word)
        begin
            if (match)
            begin
                job.n    = rep_len;
                job.data = {{(JOB_BYTES-8)*BYTE_W{1'b0}}, cfg.replacement_word};
            end
            else
            begin
                job.n = eff_cnt;
            end
        end
        // drop a job that yields no beat unless it closes the string
        push = accept && (in_last || job.sep || job.n != '0);
    end

    always_comb
    begin
        count_next   = count_reg;
        pass_next    = pass_reg;
        emitted_next = emitted_reg;
        if (accept)
        begin
            if (in_last)
            begin
                count_next   = '0;
                pass_next    = 1'b0;
                emitted_next = 1'b0;
            end
            else
            begin
                if (store)
                    count_next = count_reg + 4'd1;
                else if (is_sp || flush)
                    count_next = '0;
                if (flush)
                    pass_next = 1'b1;
                else if (is_sp)
                    pass_next = 1'b0;
                emitted_next = emitted_reg || emit_word || flush;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pass_reg    <= 1'b0;
            emitted_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            pass_reg    <= pass_next;
            emitted_reg <= emitted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_WORD_BYTES; i++)
            if (accept && store && count_reg == CNT_W'(i))
                word_mem[i] <= in_byte;
    end

endmodule

`default_nettype wire

// File: hdl/wwr_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module wwr_fifo import wwr_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_job,
    output logic      full
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);

    job_t              slot [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_QW'(Q_DEPTH));
    assign head_job   = slot[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot[wr_ptr_reg] <= push_job;
    end

`include "whole_word_replacer_assert.svh"

    `WWR_ASSERT_IMP(fifo_count_in_range, 1'b1, count_reg <= CNT_QW'(Q_DEPTH))
    `WWR_ASSERT_IMP(fifo_no_push_when_full, push, !full)

endmodule

`default_nettype wire

// File: hdl/wwr_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module wwr_emit import wwr_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire job_t              head_job,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [BYTE_W-1:0]      out_byte,
    output logic                   out_has_byte,
    output logic                   out_last
);

    logic [CNT_W-1:0]  pos_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_has_byte_reg, out_last_reg;

    logic [CNT_W-1:0]  total, idx;
    logic              advance, last_item;
    logic [BYTE_W-1:0] item_byte;

    always_comb
    begin
        total     = {{(CNT_W-1){1'b0}}, head_job.sep} + head_job.n;
        idx       = pos_reg - {{(CNT_W-1){1'b0}}, head_job.sep};
        last_item = (total == '0) || (pos_reg == total - 4'd1);
        advance   = head_valid && (!out_valid_reg || !out_stall);
        pop       = advance && last_item;
        if (total == '0)
            item_byte = '0;
        else if (head_job.sep && pos_reg == '0)
            item_byte = SPACE_BYTE;
        else
            item_byte = head_job.data[{idx, 3'b000} +: BYTE_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                pos_reg <= last_item ? '0 : pos_reg + 4'd1;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // load a new beat only when the previous one has gone
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg     <= item_byte;
            out_has_byte_reg <= (total != '0);
            out_last_reg     <= head_job.last && last_item;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_has_byte = out_has_byte_reg;
    assign out_last     = out_last_reg;

`include "whole_word_replacer_assert.svh"

    `WWR_ASSERT_IMP(emit_pos_within_job, head_valid && total != '0, pos_reg < total)
    `WWR_ASSERT_IMP(emit_pos_idle_zero, !head_valid, pos_reg == '0)

endmodule

`default_nettype wire

// File: hdl/whole_word_replacer.sv
// whole_word_replacer: rewrites a byte stream word by word.
// Input channel (in_valid/in_stall): one text byte per beat, in_last closes the
// string, in_empty marks a beat that carries no byte (only the end mark if in_last). Words are split
// on spaces; a word equal to the target (exact or ASCII case-blind) is swapped
// for the replacement, and words go out joined by single spaces.
// Output channel (out_valid/out_stall): one byte per beat, or an end-only
// marker (out_has_byte low) when a closing beat yields nothing; out_last flags
// the final beat of each string.
// Configuration: write cfg_data to register cfg_index while cfg_write is high,
// only while the block is idle.
// The beat ending a word queues its job; the emitter then registers its bytes.
// Throughput: one input beat per cycle while the 4-entry job queue has room;
// the emitter sends one output beat per cycle while out_stall is low, and an
// overlong word flush yields up to 10 output beats.
// Receiver stall holds the output register; the queue then fills and in_stall
// rises. Reset clears word state, the queue and the output, and returns the
// registers to target length 1, exact compare, empty replacement.
`timescale 1ns / 1ps
`default_nettype none

module whole_word_replacer import wwr_pkg::*; #(
    parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [BYTE_W-1:0]     in_byte,
    input  wire logic                  in_last,
    input  wire logic                  in_empty,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [BYTE_W-1:0]          out_byte,
    output logic                       out_has_byte,
    output logic                       out_last
);

    cfg_t cfg_reg;
    logic push, pop, head_valid, full, accept;
    job_t push_job, head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_word        <= '0;
            cfg_reg.target_length      <= 4'd1;
            cfg_reg.replacement_word   <= '0;
            cfg_reg.replacement_length <= '0;
            cfg_reg.match_case         <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TARGET_WORD:        cfg_reg.target_word        <= cfg_data;
                CFG_TARGET_LENGTH:      cfg_reg.target_length      <= cfg_data[CNT_W-1:0];
                CFG_REPLACEMENT_WORD:   cfg_reg.replacement_word   <= cfg_data;
                CFG_REPLACEMENT_LENGTH: cfg_reg.replacement_length <= cfg_data[CNT_W-1:0];
                CFG_MATCH_CASE:         cfg_reg.match_case         <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    assign in_stall = full;
    assign accept   = in_valid && !full;

    wwr_front #(
        .MAX_WORD_BYTES(MAX_WORD_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .in_empty(in_empty),
        .push    (push),
        .job     (push_job)
    );

    wwr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head_valid(head_valid),
        .head_job  (head_job),
        .full      (full)
    );

    wwr_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .out_has_byte(out_has_byte),
        .out_last    (out_last)
    );

endmodule

`default_nettype wire

// File: verif/whole_word_replacer_tb.sv
`timescale 1ns / 1ps

module whole_word_replacer_tb;
    import wwr_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has_byte;
        logic              last;
    } out_beat_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              empty;
        bit                typed;
        string             text;
    } text_beat_t;

    typedef struct {
        int                phase;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              empty;
        bit                typed;
        string             text;
    } directed_row_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_TARGET_WORD;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     in_byte      = '0;
    logic                  in_last      = 1'b0;
    logic                  in_empty     = 1'b0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic                  out_has_byte;
    logic                  out_last;

    whole_word_replacer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .in_empty     (in_empty),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .out_has_byte (out_has_byte),
        .out_last     (out_last)
    );

    always #5 clk = ~clk;

    // shadow registers and word state of the rewriter
    cfg_t              rules;
    logic [BYTE_W-1:0] word_buf [8];
    int                word_len     = 0;
    bit                long_pass    = 1'b0;
    bit                word_out     = 1'b0;

    out_beat_t         step_out [$];
    out_beat_t         pending_out [$];
    text_beat_t        beat_q [$];
    logic [BYTE_W-1:0] draft_text [$];
    text_beat_t        nxt;
    bit                cur_typed    = 1'b0;
    string             cur_text     = "";
    int                burst_left   = 1;
    int                gap_left     = 0;
    int                items_queued = 0;
    int                mismatches   = 0;
    int                stall_tick   = 0;
    stall_style_t      stall_style  = STALL_NONE;

    function automatic void emit_beat(logic [BYTE_W-1:0] b, logic has, logic last);
        out_beat_t o;
        o = '{data: b, has_byte: has, last: last};
        step_out.insert(step_out.size(), o);
    endfunction

    function automatic void expect_beat(logic [BYTE_W-1:0] b, logic has, logic last);
        out_beat_t o;
        o = '{data: b, has_byte: has, last: last};
        pending_out.insert(pending_out.size(), o);
    endfunction

    function automatic void add_text(logic [BYTE_W-1:0] b);
        draft_text.insert(draft_text.size(), b);
    endfunction

    function automatic void add_beat(logic [BYTE_W-1:0] b, logic last, logic empty,
                                     bit typed, string text);
        text_beat_t t;
        t.data  = b;
        t.last  = last;
        t.empty = empty;
        t.typed = typed;
        t.text  = text;
        beat_q.insert(beat_q.size(), t);
    endfunction

    function automatic logic [BYTE_W-1:0] fold_case(logic [BYTE_W-1:0] b);
        if (!rules.match_case && b >= 8'd65 && b <= 8'd90)
            return b + 8'd32;
        return b;
    endfunction

    function automatic void emit_byte(logic [BYTE_W-1:0] b);
        emit_beat(b, 1'b1, 1'b0);
    endfunction

    function automatic void emit_gap();
        if (word_out)
            emit_byte(SPACE_BYTE);
        word_out = 1'b1;
    endfunction

    function automatic bit is_target();
        int i;
        if (word_len != int'(rules.target_length))
            return 1'b0;
        for (i = 0; i < word_len; i++)
            if (fold_case(word_buf[i]) != fold_case(rules.target_word[8*i +: 8]))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void close_word();
        int i;
        int n;
        if (long_pass)
        begin
            long_pass = 1'b0;
            word_len  = 0;
            return;
        end
        if (word_len == 0)
            return;
        emit_gap();
        if (is_target())
        begin
            n = (rules.replacement_length > 4'd8) ? 8 : int'(rules.replacement_length);
            for (i = 0; i < n; i++)
                emit_byte(rules.replacement_word[8*i +: 8]);
        end
        else
        begin
            for (i = 0; i < word_len; i++)
                emit_byte(word_buf[i]);
        end
        word_len = 0;
    endfunction

    function automatic void absorb_byte(logic [BYTE_W-1:0] b);
        int i;
        if (b == SPACE_BYTE)
            close_word();
        else if (long_pass)
            emit_byte(b);
        else if (word_len < 8)
        begin
            word_buf[word_len] = b;
            word_len++;
        end
        else
        begin
            // a ninth byte cannot match: flush the buffer and pass the rest through
            emit_gap();
            for (i = 0; i < word_len; i++)
                emit_byte(word_buf[i]);
            emit_byte(b);
            word_len  = 0;
            long_pass = 1'b1;
        end
    endfunction

    function automatic void rewrite_beat(logic [BYTE_W-1:0] b, logic last, logic empty);
        step_out.delete();
        if (!empty)
            absorb_byte(b);
        if (last)
        begin
            close_word();
            if (step_out.size() > 0)
                step_out[step_out.size()-1].last = 1'b1;
            else
                emit_beat(8'd0, 1'b0, 1'b1);
            word_len  = 0;
            long_pass = 1'b0;
            word_out  = 1'b0;
        end
    endfunction

    function automatic void push_typed(string text, logic last);
        int i;
        if (text.len() == 0 && last)
            expect_beat(8'd0, 1'b0, 1'b1);
        for (i = 0; i < text.len(); i++)
            expect_beat(text[i], 1'b1, last && (i == text.len() - 1));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_letter();
        logic [BYTE_W-1:0] ch;
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom_range(0, 255));
        ch = 8'(8'd97 + $urandom_range(0, 5));
        if ($urandom_range(0, 1) == 1)
            ch = ch - 8'd32;
        return ch;
    endfunction

    function automatic cfg_t random_rules(int phase);
        cfg_t c;
        int   i;
        for (i = 0; i < 8; i++)
        begin
            c.target_word[8*i +: 8]      = rand_letter();
            c.replacement_word[8*i +: 8] = 8'($urandom_range(0, 255));
        end
        c.target_length      = 4'($urandom_range(1, 8));
        c.replacement_length = 4'($urandom_range(0, 15));
        c.match_case         = 1'($urandom_range(0, 1));
        case (phase)
            0:
            begin
                c.target_word        = '1;
                c.target_length      = 4'd8;
                c.replacement_word   = '1;
                c.replacement_length = 4'd8;
                c.match_case         = 1'b1;
            end
            1: c.target_length = 4'd0;
            2: c.target_length = 4'd15;
            3:
            begin
                c.replacement_length = 4'd0;
                c.match_case         = 1'b0;
            end
            4: c.replacement_length = 4'd15;
            default: ;
        endcase
        return c;
    endfunction

    function automatic void add_word();
        int                i;
        int                n;
        int                kind;
        int                tl;
        logic [BYTE_W-1:0] ch;
        tl   = int'(rules.target_length);
        kind = $urandom_range(0, 9);
        if (kind < 4 && tl >= 1 && tl <= 8)
        begin
            for (i = 0; i < tl; i++)
            begin
                ch = rules.target_word[8*i +: 8];
                if (((ch >= 8'd65 && ch <= 8'd90) || (ch >= 8'd97 && ch <= 8'd122))
                    && $urandom_range(0, 3) == 0)
                    ch = ch ^ 8'h20;
                add_text(ch);
            end
            // near miss: one byte longer, shorter, or off by one bit
            if (kind == 3)
            begin
                case ($urandom_range(0, 2))
                    0: add_text(rand_letter());
                    1: if (tl > 1) void'(draft_text.pop_back());
                    default:
                        draft_text[draft_text.size()-1] =
                            draft_text[draft_text.size()-1] ^ 8'h01;
                endcase
            end
        end
        else
        begin
            n = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                add_text(rand_letter());
        end
    endfunction

    function automatic void queue_string();
        int i;
        int w;
        int nwords;
        draft_text.delete();
        nwords = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) add_text(SPACE_BYTE);
        for (w = 0; w < nwords; w++)
        begin
            if (w > 0)
            begin
                add_text(SPACE_BYTE);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 2)) add_text(SPACE_BYTE);
            end
            add_word();
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) add_text(SPACE_BYTE);
        for (i = 0; i < draft_text.size(); i++)
        begin
            if ($urandom_range(0, 24) == 0)
                add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, "");
            add_beat(draft_text[i], 1'b0, 1'b0, 1'b0, "");
            items_queued++;
        end
        // close on the final byte, or on a separate end-only beat
        if (draft_text.size() > 0 && $urandom_range(0, 9) < 7)
            beat_q[beat_q.size()-1].last = 1'b1;
        else
        begin
            add_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0, "");
            items_queued++;
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    task automatic load_rules(cfg_t c);
        write_reg(CFG_TARGET_WORD, c.target_word);
        write_reg(CFG_TARGET_LENGTH, CFG_DATA_W'(c.target_length));
        write_reg(CFG_REPLACEMENT_WORD, c.replacement_word);
        write_reg(CFG_REPLACEMENT_LENGTH, CFG_DATA_W'(c.replacement_length));
        write_reg(CFG_MATCH_CASE, CFG_DATA_W'(c.match_case));
        @(posedge clk);
        cfg_write <= 1'b0;
        rules = c;
    endtask

    task automatic wait_idle();
        while (beat_q.size() != 0 || in_valid || pending_out.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic note_mismatch(string what, out_beat_t want, out_beat_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"mismatch (%s): want byte %02h has %0d last %0d, ",
                      "got byte %02h has %0d last %0d"},
                     what, want.data, want.has_byte, want.last,
                     got.data, got.has_byte, got.last);
    endtask

    // sender: bursts of random length, random gaps between them
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                rewrite_beat(in_byte, in_last, in_empty);
                if (cur_typed)
                    push_typed(cur_text, in_last);
                else
                    foreach (step_out[k])
                        pending_out.insert(pending_out.size(), step_out[k]);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (beat_q.size() != 0)
                begin
                    nxt = beat_q.pop_front();
                    in_byte   <= nxt.data;
                    in_last   <= nxt.last;
                    in_empty  <= nxt.empty;
                    in_valid  <= 1'b1;
                    cur_typed <= nxt.typed;
                    cur_text  <= nxt.text;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall style changes every so often
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            stall_tick++;
            if (stall_tick % 160 == 0)
                stall_style = stall_style_t'($urandom_range(0, 3));
            case (stall_style)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                default:     out_stall <= ((stall_tick % 7) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_out.size() == 0)
                note_mismatch("nothing expected", '0, {out_byte, out_has_byte, out_last});
            else if (pending_out[0].data !== out_byte || pending_out[0].has_byte !== out_has_byte
                     || pending_out[0].last !== out_last)
                note_mismatch("wrong beat", pending_out.pop_front(),
                              {out_byte, out_has_byte, out_last});
            else
                void'(pending_out.pop_front());
        end
    end

    cfg_t directed_rules [4] = '{
        '{64'd0, 4'd1, 64'd0, 4'd0, 1'b1},
        '{64'h0000_0000_0074_6163, 4'd3, 64'h0000_0000_2167_6F64, 4'd4, 1'b0},
        '{64'h0000_0000_0000_0062, 4'd1, 64'd0, 4'd0, 1'b1},
        '{64'h0000_0000_0000_00C1, 4'd1, 64'h4847_4645_4443_4241, 4'd15, 1'b0}
    };

    directed_row_t directed_rows [31] = '{
        // end-only beat, lone space, zero byte replaced by nothing: each gives a bare end mark
        '{0, 8'h00, 1'b1, 1'b1, 1'b1, ""},
        '{0, 8'h20, 1'b1, 1'b0, 1'b1, ""},
        '{0, 8'h00, 1'b1, 1'b0, 1'b1, ""},
        '{0, 8'hFF, 1'b0, 1'b1, 1'b1, ""},
        '{0, 8'hFF, 1'b1, 1'b0, 1'b0, ""},
        // case-blind match after a leading space
        '{1, 8'h20, 1'b0, 1'b0, 1'b1, ""},
        '{1, 8'h43, 1'b0, 1'b0, 1'b1, ""},
        '{1, 8'h61, 1'b0, 1'b0, 1'b1, ""},
        '{1, 8'h54, 1'b0, 1'b0, 1'b1, ""},
        '{1, 8'h20, 1'b0, 1'b0, 1'b1, "dog!"},
        '{1, 8'h78, 1'b0, 1'b0, 1'b1, ""},
        '{1, 8'h59, 1'b1, 1'b0, 1'b1, " xY"},
        // empty replacement keeps both separators
        '{2, 8'h61, 1'b0, 1'b0, 1'b1, ""},
        '{2, 8'h20, 1'b0, 1'b0, 1'b1, "a"},
        '{2, 8'h62, 1'b0, 1'b0, 1'b1, ""},
        '{2, 8'h20, 1'b0, 1'b0, 1'b1, " "},
        '{2, 8'h63, 1'b1, 1'b0, 1'b1, " c"},
        // high bytes are not folded; oversized replacement length; overlong word
        '{3, 8'hE1, 1'b0, 1'b0, 1'b0, ""},
        '{3, 8'h20, 1'b0, 1'b0, 1'b0, ""},
        '{3, 8'hC1, 1'b0, 1'b0, 1'b0, ""},
        '{3, 8'h20, 1'b0, 1'b0, 1'b0, ""},
        '{3, 8'h61, 1'b0, 1'b0, 1'b1, ""},
        '{3, 8'h62, 1'b0, 1'b0, 1'b1, ""},
        '{3, 8'h63, 1'b0, 1'b0, 1'b1, ""},
        '{3, 8'h64, 1'b0, 1'b0, 1'b1, ""},
        '{3, 8'h65, 1'b0, 1'b0, 1'b1, ""},
        '{3, 8'h66, 1'b0, 1'b0, 1'b1, ""},
        '{3, 8'h67, 1'b0, 1'b0, 1'b1, ""},
        '{3, 8'h68, 1'b0, 1'b0, 1'b1, ""},
        '{3, 8'h69, 1'b0, 1'b0, 1'b0, ""},
        '{3, 8'h20, 1'b1, 1'b0, 1'b1, ""}
    };

    initial
    begin
        int p;
        int r;
        rules = '{64'd0, 4'd1, 64'd0, 4'd0, 1'b1};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < 4; p++)
        begin
            wait_idle();
            load_rules(directed_rules[p]);
            for (r = 0; r < 31; r++)
                if (directed_rows[r].phase == p)
                    add_beat(directed_rows[r].data, directed_rows[r].last,
                             directed_rows[r].empty, directed_rows[r].typed,
                             directed_rows[r].text);
        end

        for (p = 0; p < 8; p++)
        begin
            wait_idle();
            load_rules(random_rules(p));
            items_queued = 0;
            while (items_queued < 36)
                queue_string();
        end

        wait_idle();
        if (mismatches == 0 && pending_out.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/wwr_pkg.sv
hdl/wwr_front.sv
hdl/wwr_fifo.sv
hdl/wwr_emit.sv
hdl/whole_word_replacer.sv
verif/whole_word_replacer_tb.sv
